FILE: hdl/status_led_pulse_blink_controller_assert.svh
// Assertion macros used by the status LED controller checker.
`ifndef STATUS_LED_PULSE_BLINK_CONTROLLER_ASSERT_SVH
`define STATUS_LED_PULSE_BLINK_CONTROLLER_ASSERT_SVH

// Clocked assertion, disabled while reset is high.
`define SLPBC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define SLPBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/slpbc_pkg.sv
// Types and codes for the status LED pulse and blink controller.
package slpbc_pkg;

   localparam int REQ_TDATA_W = 8;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int DUTY_W      = 12;
   localparam int STEP_W      = 8;
   localparam int TOP_W       = 11;
   localparam int PHASE_W     = 8;
   localparam int PHASES_W    = 3;

   // input command codes
   localparam logic [2:0] CMD_TICK  = 3'd0;
   localparam logic [2:0] CMD_OFF   = 3'd1;
   localparam logic [2:0] CMD_ON    = 3'd2;
   localparam logic [2:0] CMD_PULSE = 3'd3;
   localparam logic [2:0] CMD_BLINK = 3'd4;

   // stored lit mode codes
   localparam logic [1:0] LIT_OFF     = 2'd0;
   localparam logic [1:0] LIT_ON      = 2'd1;
   localparam logic [1:0] LIT_PULSING = 2'd2;

   // drive codes
   localparam logic [1:0] DRIVE_LOW  = 2'd0;
   localparam logic [1:0] DRIVE_HIGH = 2'd1;
   localparam logic [1:0] DRIVE_PWM  = 2'd2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_PULSE_STEP  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PULSE_TOP   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_BLINK_PHASE = 2'd2;

   // bit positions of result fields in rsp_tdata
   localparam int RSP_DRIVE_LSB   = 0;
   localparam int RSP_DUTY_LSB    = 2;
   localparam int RSP_BUSY_BIT    = 14;
   localparam int RSP_LIT_LSB     = 15;
   localparam int RSP_DROPPED_BIT = 17;

   // result item, lowest field in the lowest bits
   typedef struct packed {
      logic [5:0]        pad;
      logic              dropped;
      logic [1:0]        lit_mode;
      logic              busy_res;
      logic [DUTY_W-1:0] duty;
      logic [1:0]        drive;
   } rsp_type;

endpackage

FILE: hdl/status_led_pulse_blink_controller.sv
// Status LED controller: off, on, breathing pulse and counted blinks.
// A result is registered in the output register, or in the skid entry while the output stalls.
// Throughput: one request per cycle while the skid entry is empty; the state update and squaring of the
// level sit between the request and a two-entry result register.
// Reset (synchronous): lit mode pulsing, level 0 rising, no blink running,
// pulse_step 10, pulse_top 1000, blink_phase_ticks 25, no result pending.
module status_led_pulse_blink_controller #(
   parameter int EASE_SHIFT = 5,
   parameter int LEVEL_BITS = 11
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [slpbc_pkg::REQ_TUSER_W-1:0]     req_tuser,  // mode[2:0]
   input  logic [slpbc_pkg::REQ_TDATA_W-1:0]     req_tdata,  // blinks[1:0], zeros
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // drive[1:0], duty[13:2], busy_res[14], lit_mode[16:15], dropped[17], zeros
   output logic [slpbc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                  csr_we,
   input  logic [slpbc_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [slpbc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int SQ_W = 2 * LEVEL_BITS;

   logic [slpbc_pkg::STEP_W-1:0]   pulse_step_ff;
   logic [slpbc_pkg::TOP_W-1:0]    pulse_top_ff;
   logic [slpbc_pkg::PHASE_W-1:0]  blink_phase_ff;

   logic [1:0]                     stored_mode_ff, stored_mode_in;
   logic [LEVEL_BITS-1:0]          level_ff, level_in;
   logic                           going_down_ff, going_down_in;
   logic [slpbc_pkg::PHASES_W-1:0] phases_left_ff, phases_left_in;
   logic [slpbc_pkg::PHASE_W-1:0]  phase_timer_ff, phase_timer_in;

   slpbc_pkg::rsp_type             out_ff, out_in, skid_ff, new_rsp;
   logic                           out_valid_ff, out_valid_in;
   logic                           skid_valid_ff, skid_valid_in;

   logic                           req_fire, rsp_fire, busy, busy_next, dropped;
   logic [2:0]                     req_mode;
   logic [1:0]                     req_count, blink_n;
   logic [slpbc_pkg::PHASE_W-1:0]  phase_len, timer_dec;
   logic [LEVEL_BITS-1:0]          top, pulse_level;
   logic                           pulse_down;
   logic [LEVEL_BITS:0]            step_ext, level_sum;
   logic [LEVEL_BITS-1:0]          eased;
   logic [SQ_W-1:0]                eased_sq;
   logic [1:0]                     drive;

   assign req_mode   = req_tuser;
   assign req_count  = req_tdata[1:0];
   assign req_tready = !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = out_valid_ff && rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_step_ff  <= slpbc_pkg::STEP_W'(10);
         pulse_top_ff   <= slpbc_pkg::TOP_W'(1000);
         blink_phase_ff <= slpbc_pkg::PHASE_W'(25);
      end else if (csr_we) begin
         if (csr_addr == slpbc_pkg::CSR_PULSE_STEP) begin
            pulse_step_ff <= csr_wdata[slpbc_pkg::STEP_W-1:0];
         end
         if (csr_addr == slpbc_pkg::CSR_PULSE_TOP) begin
            pulse_top_ff <= csr_wdata[slpbc_pkg::TOP_W-1:0];
         end
         if (csr_addr == slpbc_pkg::CSR_BLINK_PHASE) begin
            blink_phase_ff <= csr_wdata[slpbc_pkg::PHASE_W-1:0];
         end
      end
   end

   // triangle step
   always_comb begin
      top        = LEVEL_BITS'(pulse_top_ff);
      step_ext   = (LEVEL_BITS + 1)'(pulse_step_ff);
      level_sum  = {1'b0, level_ff} + step_ext;
      pulse_down = going_down_ff;
      if (level_ff >= top) begin
         pulse_down = 1'b1;
      end else if (level_ff == '0) begin
         pulse_down = 1'b0;
      end
      if (pulse_down) begin
         pulse_level = ({1'b0, level_ff} > step_ext) ?
                       level_ff - LEVEL_BITS'(pulse_step_ff) : '0;
      end else begin
         pulse_level = (level_sum > {1'b0, top}) ? top : level_sum[LEVEL_BITS-1:0];
      end
   end

   assign phase_len = (blink_phase_ff == '0) ? slpbc_pkg::PHASE_W'(1) : blink_phase_ff;
   assign timer_dec = (phase_timer_ff != '0) ? phase_timer_ff - 1'b1 : '0;
   assign blink_n   = (req_count == 2'd0) ? 2'd1 : req_count;
   assign busy      = phases_left_ff != '0;

   // per-item state update
   always_comb begin
      stored_mode_in = stored_mode_ff;
      level_in       = level_ff;
      going_down_in  = going_down_ff;
      phases_left_in = phases_left_ff;
      phase_timer_in = phase_timer_ff;
      dropped        = 1'b0;
      unique case (req_mode)
         slpbc_pkg::CMD_TICK: begin
            if (busy) begin
               phase_timer_in = timer_dec;
               if (timer_dec == '0) begin
                  phases_left_in = phases_left_ff - 1'b1;
                  if (phases_left_in != '0) begin
                     phase_timer_in = phase_len;
                  end
               end
            end else if (stored_mode_ff == slpbc_pkg::LIT_PULSING) begin
               level_in      = pulse_level;
               going_down_in = pulse_down;
            end
         end
         slpbc_pkg::CMD_OFF, slpbc_pkg::CMD_ON, slpbc_pkg::CMD_PULSE,
         slpbc_pkg::CMD_BLINK: begin
            if (busy) begin
               dropped = 1'b1;
            end else if (req_mode == slpbc_pkg::CMD_OFF) begin
               stored_mode_in = slpbc_pkg::LIT_OFF;
            end else if (req_mode == slpbc_pkg::CMD_ON) begin
               stored_mode_in = slpbc_pkg::LIT_ON;
            end else if (req_mode == slpbc_pkg::CMD_PULSE) begin
               stored_mode_in = slpbc_pkg::LIT_PULSING;
            end else begin
               phases_left_in = {blink_n, 1'b0};
               phase_timer_in = phase_len;
            end
         end
         default: begin
         end
      endcase
   end

   // result item
   always_comb begin
      busy_next = phases_left_in != '0;
      if (busy_next) begin
         drive = phases_left_in[0] ? slpbc_pkg::DRIVE_LOW : slpbc_pkg::DRIVE_HIGH;
      end else if (stored_mode_in == slpbc_pkg::LIT_OFF) begin
         drive = slpbc_pkg::DRIVE_LOW;
      end else if (stored_mode_in == slpbc_pkg::LIT_ON) begin
         drive = slpbc_pkg::DRIVE_HIGH;
      end else begin
         drive = slpbc_pkg::DRIVE_PWM;
      end
      eased            = level_in >> EASE_SHIFT;
      eased_sq         = SQ_W'(eased) * SQ_W'(eased);
      new_rsp.pad      = '0;
      new_rsp.dropped  = dropped;
      new_rsp.lit_mode = stored_mode_in;
      new_rsp.busy_res = busy_next;
      new_rsp.duty     = eased_sq[slpbc_pkg::DUTY_W-1:0];
      new_rsp.drive    = drive;
   end

   // output register with skid entry
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_fire) begin
         out_valid_in  = skid_valid_ff || req_fire;
         out_in        = skid_valid_ff ? skid_ff : new_rsp;
         skid_valid_in = 1'b0;
      end else if (req_fire) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_mode_ff <= slpbc_pkg::LIT_PULSING;
         level_ff       <= '0;
         going_down_ff  <= 1'b0;
         phases_left_ff <= '0;
         phase_timer_ff <= '0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (req_fire) begin
            stored_mode_ff <= stored_mode_in;
            level_ff       <= level_in;
            going_down_ff  <= going_down_in;
            phases_left_ff <= phases_left_in;
            phase_timer_ff <= phase_timer_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (req_fire && out_valid_ff && !rsp_fire) begin
         skid_ff <= new_rsp;
      end
   end

endmodule

FILE: hdl/slpbc_checker.sv
// Port-level checks for the status LED controller, bound to the top level.
`include "status_led_pulse_blink_controller_assert.svh"

module slpbc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [slpbc_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic [1:0] drive;
   logic [1:0] lit_mode;
   logic       busy;
   logic       dropped;

   assign drive    = rsp_tdata[slpbc_pkg::RSP_DRIVE_LSB +: 2];
   assign lit_mode = rsp_tdata[slpbc_pkg::RSP_LIT_LSB +: 2];
   assign busy     = rsp_tdata[slpbc_pkg::RSP_BUSY_BIT];
   assign dropped  = rsp_tdata[slpbc_pkg::RSP_DROPPED_BIT];

   `SLPBC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result after reset")
   `SLPBC_ASSERT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `SLPBC_ASSERT(a_drop_busy, clock, reset, rsp_tvalid && dropped |-> busy,
      "dropped command without running blink")
   `SLPBC_ASSERT(a_blink_no_pwm, clock, reset,
      rsp_tvalid && busy |-> drive != slpbc_pkg::DRIVE_PWM, "pwm drive during blink")
   `SLPBC_ASSERT(a_idle_drive, clock, reset,
      rsp_tvalid && !busy |-> (lit_mode == slpbc_pkg::LIT_OFF && drive == slpbc_pkg::DRIVE_LOW)
      || (lit_mode == slpbc_pkg::LIT_ON && drive == slpbc_pkg::DRIVE_HIGH)
      || (lit_mode == slpbc_pkg::LIT_PULSING && drive == slpbc_pkg::DRIVE_PWM),
      "idle drive does not follow lit mode")

endmodule

bind status_led_pulse_blink_controller slpbc_checker u_slpbc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
